// ----- src/gse_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_pkg
// Shared constants, register codes and configuration type of the grid
// sample engine.
// ----------------------------------------------------------------------------
package gse_pkg;

  localparam int unsigned DEF_MAX_WIDTH    = 64;
  localparam int unsigned DEF_MAX_HEIGHT   = 64;
  localparam int unsigned DEF_MAX_CHANNELS = 4;
  localparam int unsigned DEF_FRAC_BITS    = 12;

  // At most this many results leave per sample
  localparam int unsigned OUT_LIMIT = 4;

  // Fraction bits of the normalized input coordinates (Q3.12)
  localparam int unsigned NORM_FRAC = 12;

  localparam logic MODE_LOAD      = 1'b0;
  localparam logic MODE_SAMPLE    = 1'b1;
  localparam logic INTERP_NEAREST = 1'b1;

  typedef enum logic [2:0] {
    REG_WIDTH    = 3'd0,
    REG_HEIGHT   = 3'd1,
    REG_CHANNELS = 3'd2,
    REG_ALIGN    = 3'd3,
    REG_PADDING  = 3'd4,
    REG_INTERP   = 3'd5
  } cfg_index_t;

  typedef enum logic [1:0] {
    PAD_ZEROS   = 2'd0,
    PAD_BORDER  = 2'd1,
    PAD_REFLECT = 2'd2
  } pad_mode_t;

  typedef struct packed {
    logic [6:0] img_width;
    logic [6:0] img_height;
    logic [2:0] channel_count;
    logic       corner_align;
    logic [1:0] pad_sel;
    logic       interp_mode;
  } cfg_t;

endpackage

// ----- src/grid_sample_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_sample_engine_unit
// Grid sampler over a stored multi-channel image: pixel loads and
// bilinear or nearest samples with zeros, border or reflection padding.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. busy covers the
// coordinate front end only: an in-range load holds it until it is queued,
// a sample through the multiply, round, pad, index and weight steps, and
// under reflection padding the remainder by the reflection period, found
// one bit a cycle; busy stays high while the queue is full. Behind a
// two-entry queue the store side does the work: one store write per load,
// up to four single-port reads and four multiply-adds per sample channel;
// this store port sets the sustained rate. Results leave one per strobe
// cycle, channel 0 first, the last marked by last_chan, and cannot be held
// off. Write configuration only while nothing is in flight (not enforced).
// ----------------------------------------------------------------------------
module grid_sample_engine_unit #(
  parameter int unsigned MAX_WIDTH    = gse_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = gse_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = gse_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned FRAC_BITS    = gse_pkg::DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic                mode,
  input  logic [5:0]          pixel_col,
  input  logic [5:0]          pixel_row,
  input  logic [1:0]          pixel_chan,
  input  logic signed [15:0]  pixel_value,
  input  logic signed [15:0]  norm_x,
  input  logic signed [15:0]  norm_y,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_index,
  input  logic [6:0]          cfg_data,
  output logic                result_strobe,
  output logic signed [15:0]  sample_value,
  output logic [1:0]          out_chan,
  output logic                last_chan
);

  localparam int unsigned WW  = 2 * FRAC_BITS + 1;
  localparam int unsigned PIW = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                                $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
  localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned ENTRY_W = 1 + PIW + CHW + 16 + 4 + 3 + 4 * WW;

  gse_pkg::cfg_t       cfg;
  logic                q_push;
  logic                q_pop;
  logic                q_full;
  logic                q_empty;
  logic [ENTRY_W-1:0]  q_in;
  logic [ENTRY_W-1:0]  q_head;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.img_width     <= 7'd64;
      cfg.img_height    <= 7'd64;
      cfg.channel_count <= 3'd1;
      cfg.corner_align  <= 1'b0;
      cfg.pad_sel       <= gse_pkg::PAD_ZEROS;
      cfg.interp_mode   <= 1'b0;
    end else if (cfg_we) begin
      unique case (gse_pkg::cfg_index_t'(cfg_index))
        gse_pkg::REG_WIDTH:    cfg.img_width     <= cfg_data;
        gse_pkg::REG_HEIGHT:   cfg.img_height    <= cfg_data;
        gse_pkg::REG_CHANNELS: cfg.channel_count <= cfg_data[2:0];
        gse_pkg::REG_ALIGN:    cfg.corner_align  <= cfg_data[0];
        gse_pkg::REG_PADDING:  cfg.pad_sel       <= cfg_data[1:0];
        gse_pkg::REG_INTERP:   cfg.interp_mode   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  gse_front #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .mode        (mode),
    .pixel_col   (pixel_col),
    .pixel_row   (pixel_row),
    .pixel_chan  (pixel_chan),
    .pixel_value (pixel_value),
    .norm_x      (norm_x),
    .norm_y      (norm_y),
    .cfg         (cfg),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_in),
    .busy        (busy)
  );

  gse_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (2)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  gse_back #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .MAX_CHANNELS (MAX_CHANNELS),
    .FRAC_BITS    (FRAC_BITS),
    .ENTRY_W      (ENTRY_W)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_empty       (q_empty),
    .q_data        (q_head),
    .q_pop         (q_pop),
    .result_strobe (result_strobe),
    .sample_value  (sample_value),
    .out_chan      (out_chan),
    .last_chan     (last_chan)
  );

endmodule

// ----- src/gse_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module gse_queue #(
  parameter int unsigned DATA_W = 8,
  parameter int unsigned DEPTH  = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] head,
  output logic              full,
  output logic              empty
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] slots [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CW-1:0]     count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      unique case ({push, pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/gse_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_front
// Accepts items, drops out-of-range loads, and turns sample points into
// corner indices, validity flags and bilinear weights for the back part.
// ----------------------------------------------------------------------------
module gse_front #(
  parameter int unsigned MAX_WIDTH    = gse_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = gse_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = gse_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned FRAC_BITS    = gse_pkg::DEF_FRAC_BITS,
  parameter int unsigned ENTRY_W      = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                mode,
  input  logic [5:0]          pixel_col,
  input  logic [5:0]          pixel_row,
  input  logic [1:0]          pixel_chan,
  input  logic signed [15:0]  pixel_value,
  input  logic signed [15:0]  norm_x,
  input  logic signed [15:0]  norm_y,
  input  gse_pkg::cfg_t       cfg,
  input  logic                q_full,
  output logic                q_push,
  output logic [ENTRY_W-1:0]  q_data,
  output logic                busy
);

  localparam int unsigned MAX_DIM = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int unsigned DW  = $clog2(MAX_DIM + 1);
  localparam int unsigned TW  = 17;
  localparam int unsigned PW  = TW + DW + 1;
  localparam int unsigned FW  = FRAC_BITS;
  localparam int unsigned UW  = PW + FW;
  localparam int unsigned IW  = UW - FW;
  localparam int unsigned QW  = $clog2(MAX_DIM) + 2;
  localparam int unsigned CW  = $clog2(QW + 1);
  localparam int unsigned EW  = DW + FW + 1;
  localparam int unsigned WW  = 2 * FW + 1;
  localparam int unsigned PIW = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                                $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
  localparam int unsigned CHW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned CHMAX = (MAX_CHANNELS < gse_pkg::OUT_LIMIT) ?
                                  MAX_CHANNELS : gse_pkg::OUT_LIMIT;
  localparam int unsigned RND_SH = gse_pkg::NORM_FRAC + 1;

  localparam logic signed [UW-1:0] HALF  = UW'(1) << (FW - 1);
  localparam logic signed [UW-1:0] RHALF = UW'(1) << gse_pkg::NORM_FRAC;
  localparam logic signed [TW-1:0] NONE  = TW'(1) << gse_pkg::NORM_FRAC;

  typedef struct packed {
    logic                   is_load;
    logic [PIW-1:0]         pix;
    logic [CHW-1:0]         chan;
    logic [15:0]            value;
    logic [3:0]             cvalid;
    logic [2:0]             nch;
    logic [3:0][WW-1:0]     wgt;
  } entry_t;

  typedef enum logic [3:0] {
    F_IDLE, F_MUL, F_RND, F_PAD, F_MOD, F_REFL, F_IDX, F_WGT, F_PUSH
  } front_state_t;

  front_state_t           state;
  logic signed [TW-1:0]   t   [2];
  logic [DW-1:0]          sz  [2];
  logic signed [PW-1:0]   m   [2];
  logic signed [UW-1:0]   u   [2];
  logic [QW-1:0]          q   [2];
  logic [FW:0]            lo  [2];
  logic [DW-1:0]          rem [2];
  logic                   zd  [2];
  logic signed [IW-1:0]   i0  [2];
  logic [FW-1:0]          fr  [2];
  logic [CW-1:0]          cnt;
  entry_t                 ent;

  // Combinational helpers, one set per axis (0 horizontal, 1 vertical)
  logic [DW-1:0]          seff    [2];
  logic signed [PW-1:0]   m_next  [2];
  logic signed [UW-1:0]   v       [2];
  logic signed [UW-1:0]   vmag    [2];
  logic signed [UW-1:0]   rmag    [2];
  logic signed [UW-1:0]   u_rnd   [2];
  logic signed [UW-1:0]   top     [2];
  logic signed [UW-1:0]   ub      [2];
  logic signed [UW-1:0]   apos    [2];
  logic signed [UW-1:0]   amag    [2];
  logic [DW:0]            rsh     [2];
  logic [DW-1:0]          rstep   [2];
  logic [EW-1:0]          e       [2];
  logic [EW-1:0]          de      [2];
  logic [EW-1:0]          e2      [2];
  logic signed [UW-1:0]   e2s     [2];
  logic signed [UW-1:0]   ur      [2];
  logic signed [UW-1:0]   umag    [2];
  logic signed [UW-1:0]   nmag    [2];
  logic signed [UW-1:0]   idx_u   [2];
  logic signed [IW-1:0]   i1      [2];
  logic                   in0     [2];
  logic                   in1     [2];
  logic [FW:0]            ofr     [2];
  logic [DW-1:0]          sz_in   [2];
  logic [6:0]             dim_cfg [2];
  logic [2:0]             nch_c;
  logic                   load_ok;
  logic [PIW-1:0]         pix_c;
  entry_t                 smp;

  assign dim_cfg[0] = cfg.img_width;
  assign dim_cfg[1] = cfg.img_height;

  always_comb begin
    for (int a = 0; a < 2; a++) begin
      // Clamp the configured size into 1..maximum
      if (dim_cfg[a] == '0) begin
        sz_in[a] = DW'(1);
      end else if (32'(dim_cfg[a]) > ((a == 0) ? MAX_WIDTH : MAX_HEIGHT)) begin
        sz_in[a] = (a == 0) ? DW'(MAX_WIDTH) : DW'(MAX_HEIGHT);
      end else begin
        sz_in[a] = DW'(dim_cfg[a]);
      end

      seff[a]   = cfg.corner_align ? sz[a] - DW'(1) : sz[a];
      m_next[a] = $signed(PW'(t[a])) * $signed(PW'({1'b0, seff[a]}));

      // Unnormalize: round half away from zero
      v[a]     = $signed(UW'(m[a])) <<< FW;
      vmag[a]  = v[a][UW-1] ? -v[a] : v[a];
      rmag[a]  = (vmag[a] + RHALF) >>> RND_SH;
      u_rnd[a] = (v[a][UW-1] ? -rmag[a] : rmag[a]) - (cfg.corner_align ? '0 : HALF);

      top[a] = UW'(sz[a] - DW'(1)) << FW;
      if (u[a][UW-1]) begin
        ub[a] = '0;
      end else if (u[a] > top[a]) begin
        ub[a] = top[a];
      end else begin
        ub[a] = u[a];
      end

      apos[a] = cfg.corner_align ? u[a] : u[a] + HALF;
      amag[a] = apos[a][UW-1] ? -apos[a] : apos[a];

      // One restoring step of the remainder by the reflection period
      rsh[a]   = {rem[a], q[a][QW-1]};
      rstep[a] = (rsh[a] >= {1'b0, seff[a]}) ? DW'(rsh[a] - {1'b0, seff[a]}) : DW'(rsh[a]);

      e[a]   = {rem[a], lo[a]};
      de[a]  = {seff[a], {(FW + 1){1'b0}}} - e[a];
      e2[a]  = (e[a] < de[a]) ? e[a] : de[a];
      e2s[a] = UW'(e2[a]);
      if (cfg.corner_align) begin
        ur[a] = zd[a] ? '0 : e2s[a];
      end else if (e2s[a] < HALF) begin
        ur[a] = '0;
      end else if (e2s[a] - HALF > top[a]) begin
        ur[a] = top[a];
      end else begin
        ur[a] = e2s[a] - HALF;
      end

      umag[a] = u[a][UW-1] ? -u[a] : u[a];
      nmag[a] = (umag[a] + HALF) >>> FW;
      if (cfg.interp_mode == gse_pkg::INTERP_NEAREST) begin
        idx_u[a] = u[a][UW-1] ? -nmag[a] : nmag[a];
      end else begin
        idx_u[a] = u[a] >>> FW;
      end

      i1[a]  = i0[a] + IW'(1);
      in0[a] = !i0[a][IW-1] && (i0[a] < $signed(IW'(sz[a])));
      in1[a] = (fr[a] != '0) && !i1[a][IW-1] && (i1[a] < $signed(IW'(sz[a])));
      ofr[a] = ((FW + 1)'(1) << FW) - {1'b0, fr[a]};
    end
  end

  always_comb begin
    if (cfg.channel_count == '0) begin
      nch_c = 3'd1;
    end else if (32'(cfg.channel_count) > CHMAX) begin
      nch_c = 3'(CHMAX);
    end else begin
      nch_c = cfg.channel_count;
    end

    load_ok = (32'(pixel_col) < MAX_WIDTH) && (32'(pixel_row) < MAX_HEIGHT) &&
              (32'(pixel_chan) < MAX_CHANNELS);
    pix_c   = PIW'(32'(pixel_row) * MAX_WIDTH + 32'(pixel_col));

    smp.is_load   = 1'b0;
    smp.pix       = PIW'(i0[1] * $signed(IW'(MAX_WIDTH)) + i0[0]);
    smp.chan      = '0;
    smp.value     = '0;
    smp.cvalid[0] = in0[0] && in0[1];
    smp.cvalid[1] = in1[0] && in0[1];
    smp.cvalid[2] = in0[0] && in1[1];
    smp.cvalid[3] = in1[0] && in1[1];
    smp.nch       = nch_c;
    smp.wgt[0]    = WW'(ofr[0]) * WW'(ofr[1]);
    smp.wgt[1]    = WW'(fr[0]) * WW'(ofr[1]);
    smp.wgt[2]    = WW'(ofr[0]) * WW'(fr[1]);
    smp.wgt[3]    = WW'(fr[0]) * WW'(fr[1]);
  end

  assign busy   = (state != F_IDLE);
  assign q_push = (state == F_PUSH) && !q_full;
  assign q_data = ENTRY_W'(ent);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (start) begin
            if (mode == gse_pkg::MODE_LOAD) begin
              ent.is_load <= 1'b1;
              ent.pix     <= pix_c;
              ent.chan    <= CHW'(pixel_chan);
              ent.value   <= pixel_value;
              ent.cvalid  <= '0;
              ent.nch     <= '0;
              ent.wgt     <= '0;
              // Drop a load outside the store
              state       <= load_ok ? F_PUSH : F_IDLE;
            end else begin
              t[0]  <= $signed(TW'(norm_x)) + NONE;
              t[1]  <= $signed(TW'(norm_y)) + NONE;
              sz[0] <= sz_in[0];
              sz[1] <= sz_in[1];
              state <= F_MUL;
            end
          end
        end
        F_MUL: begin
          m[0]  <= m_next[0];
          m[1]  <= m_next[1];
          state <= F_RND;
        end
        F_RND: begin
          u[0]  <= u_rnd[0];
          u[1]  <= u_rnd[1];
          state <= F_PAD;
        end
        F_PAD: begin
          unique case (gse_pkg::pad_mode_t'(cfg.pad_sel))
            gse_pkg::PAD_BORDER: begin
              u[0]  <= ub[0];
              u[1]  <= ub[1];
              state <= F_IDX;
            end
            gse_pkg::PAD_REFLECT: begin
              for (int a = 0; a < 2; a++) begin
                q[a]   <= QW'(amag[a] >>> (FW + 1));
                lo[a]  <= amag[a][FW:0];
                rem[a] <= '0;
                zd[a]  <= cfg.corner_align && (seff[a] == '0);
              end
              cnt   <= CW'(QW);
              state <= F_MOD;
            end
            default: begin
              state <= F_IDX;
            end
          endcase
        end
        F_MOD: begin
          for (int a = 0; a < 2; a++) begin
            rem[a] <= rstep[a];
            q[a]   <= q[a] << 1;
          end
          cnt <= cnt - CW'(1);
          if (cnt == CW'(1)) begin
            state <= F_REFL;
          end
        end
        F_REFL: begin
          u[0]  <= ur[0];
          u[1]  <= ur[1];
          state <= F_IDX;
        end
        F_IDX: begin
          for (int a = 0; a < 2; a++) begin
            i0[a] <= IW'(idx_u[a]);
            fr[a] <= (cfg.interp_mode == gse_pkg::INTERP_NEAREST) ? '0 : u[a][FW-1:0];
          end
          state <= F_WGT;
        end
        F_WGT: begin
          ent   <= smp;
          state <= F_PUSH;
        end
        F_PUSH: begin
          if (!q_full) begin
            state <= F_IDLE;
          end
        end
        default: begin
          state <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/gse_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_back
// Owns the image store: writes loads, and for samples reads up to four
// corners per channel, accumulates the weighted sum, rounds and saturates.
// ----------------------------------------------------------------------------
module gse_back #(
  parameter int unsigned MAX_WIDTH    = gse_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT   = gse_pkg::DEF_MAX_HEIGHT,
  parameter int unsigned MAX_CHANNELS = gse_pkg::DEF_MAX_CHANNELS,
  parameter int unsigned FRAC_BITS    = gse_pkg::DEF_FRAC_BITS,
  parameter int unsigned ENTRY_W      = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  logic [ENTRY_W-1:0]  q_data,
  output logic                q_pop,
  output logic                result_strobe,
  output logic signed [15:0]  sample_value,
  output logic [1:0]          out_chan,
  output logic                last_chan
);

  localparam int unsigned FW    = FRAC_BITS;
  localparam int unsigned WW    = 2 * FW + 1;
  localparam int unsigned AW    = 16 + 2 * FW + 3;
  localparam int unsigned PIW   = (MAX_WIDTH * MAX_HEIGHT > 1) ?
                                  $clog2(MAX_WIDTH * MAX_HEIGHT) : 1;
  localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned DEPTH = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int unsigned MAW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic signed [AW-1:0] RHALF  = AW'(1) << (2 * FW - 1);
  localparam logic signed [AW-1:0] SAT_HI = AW'(32767);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);

  typedef struct packed {
    logic                   is_load;
    logic [PIW-1:0]         pix;
    logic [CHW-1:0]         chan;
    logic [15:0]            value;
    logic [3:0]             cvalid;
    logic [2:0]             nch;
    logic [3:0][WW-1:0]     wgt;
  } entry_t;

  typedef enum logic [2:0] {
    B_IDLE, B_WRITE, B_READ, B_MUL, B_ACC, B_OUT
  } back_state_t;

  back_state_t           state;
  entry_t                ent;
  entry_t                head;
  logic [1:0]            k;
  logic [2:0]            c;
  logic [15:0]           rdata;
  logic signed [AW-1:0]  prod;
  logic signed [AW-1:0]  acc;
  logic [15:0]           store [DEPTH];

  logic [PIW-1:0]        pix_k;
  logic [MAW-1:0]        addr;
  logic signed [AW-1:0]  prod_next;
  logic signed [AW-1:0]  amag;
  logic signed [AW-1:0]  rmag;
  logic signed [AW-1:0]  rnd;
  logic signed [15:0]    sat;
  logic                  last;

  assign head  = entry_t'(q_data);
  assign q_pop = (state == B_IDLE) && !q_empty;

  always_comb begin
    unique case (k)
      2'd0: pix_k = ent.pix;
      2'd1: pix_k = ent.pix + PIW'(1);
      2'd2: pix_k = ent.pix + PIW'(MAX_WIDTH);
      2'd3: pix_k = ent.pix + PIW'(MAX_WIDTH + 1);
      default: pix_k = ent.pix;
    endcase

    if (state == B_WRITE) begin
      addr = MAW'(32'(ent.pix) * MAX_CHANNELS + 32'(ent.chan));
    end else begin
      addr = MAW'(32'(pix_k) * MAX_CHANNELS + 32'(c));
    end

    prod_next = ent.cvalid[k] ?
                $signed(AW'($signed(rdata))) * $signed(AW'({1'b0, ent.wgt[k]})) : '0;

    amag = acc[AW-1] ? -acc : acc;
    rmag = (amag + RHALF) >>> (2 * FW);
    rnd  = acc[AW-1] ? -rmag : rmag;
    if (rnd > SAT_HI) begin
      sat = 16'sh7FFF;
    end else if (rnd < SAT_LO) begin
      sat = -16'sh7FFF - 16'sh0001;
    end else begin
      sat = 16'(rnd);
    end

    last = ((c + 3'd1) == ent.nch);
  end

  always_ff @(posedge clk) begin
    if (state == B_WRITE) begin
      store[addr] <= ent.value;
    end
    if ((state == B_READ) && ent.cvalid[k]) begin
      rdata <= store[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      unique case (state)
        B_IDLE: begin
          if (!q_empty) begin
            ent   <= head;
            c     <= '0;
            k     <= '0;
            acc   <= '0;
            prod  <= '0;
            state <= head.is_load ? B_WRITE : B_READ;
          end
        end
        B_WRITE: begin
          state <= B_IDLE;
        end
        B_READ: begin
          // Fold in the previous corner while this one is read
          acc   <= acc + prod;
          state <= B_MUL;
        end
        B_MUL: begin
          prod <= prod_next;
          if (k == 2'd3) begin
            state <= B_ACC;
          end else begin
            k     <= k + 2'd1;
            state <= B_READ;
          end
        end
        B_ACC: begin
          acc   <= acc + prod;
          state <= B_OUT;
        end
        B_OUT: begin
          result_strobe <= 1'b1;
          sample_value  <= sat;
          out_chan      <= c[1:0];
          last_chan     <= last;
          if (last) begin
            state <= B_IDLE;
          end else begin
            c     <= c + 3'd1;
            k     <= '0;
            acc   <= '0;
            prod  <= '0;
            state <= B_READ;
          end
        end
        default: begin
          state <= B_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- src/gse_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gse_checker
// Port-level checks of the grid sample engine, bound to the top level.
// ----------------------------------------------------------------------------
module gse_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       mode,
  input logic       result_strobe,
  input logic [1:0] out_chan,
  input logic       last_chan
);

  // Nothing comes out of reset in flight
  a_reset_quiet: assert property (@(posedge clk) rst |=> !result_strobe && !busy)
    else $error("output or busy active after reset");

  // A sample transfer always occupies the front end
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && (mode == 1'b1) |=> busy)
    else $error("sample transfer did not raise busy");

  // Channel results are spaced by the multiply-add sequence
  a_strobe_gap: assert property (@(posedge clk) disable iff (rst)
    result_strobe |=> !result_strobe)
    else $error("results on consecutive cycles");

  // Channel three is always the final one
  a_last_chan: assert property (@(posedge clk) disable iff (rst)
    result_strobe && (out_chan == 2'd3) |-> last_chan)
    else $error("channel three not marked last");

endmodule

bind grid_sample_engine_unit gse_checker u_gse_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .mode          (mode),
  .result_strobe (result_strobe),
  .out_chan      (out_chan),
  .last_chan     (last_chan)
);

// ----- test/grid_sample_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_sample_checker
// Watches the item, configuration and result channels of the grid sample
// engine, predicts each sample's per-channel values and compares them.
// ----------------------------------------------------------------------------
module grid_sample_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  logic               mode,
  input  logic [5:0]         pixel_col,
  input  logic [5:0]         pixel_row,
  input  logic [1:0]         pixel_chan,
  input  logic signed [15:0] pixel_value,
  input  logic signed [15:0] norm_x,
  input  logic signed [15:0] norm_y,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               result_strobe,
  input  logic signed [15:0] sample_value,
  input  logic [1:0]         out_chan,
  input  logic               last_chan,
  output int                 fail_count,
  output int                 pending_count
);

  localparam int FB = 12;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint HALF = 64'sd1 << (FB - 1);

  typedef struct packed {
    logic signed [15:0] value;
    logic [1:0]         chan;
    logic               last;
  } sample_res_t;

  logic [15:0]   pixels [0:16383];
  gse_pkg::cfg_t cfg;
  sample_res_t   expected_q[$];

  function automatic longint fl_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint rnd_shift(longint v, int s);
    longint h;
    h = 64'sd1 <<< (s - 1);
    if (v >= 0) return (v + h) >>> s;
    return -((-v + h) >>> s);
  endfunction

  function automatic int dim_of(logic [6:0] v);
    if (v < 1) return 1;
    return (v > 64) ? 64 : int'(v);
  endfunction

  function automatic longint unnorm(longint n, int size);
    longint top, u, dr, a, e;
    top = longint'(size - 1) * ONE;
    if (cfg.corner_align) u = rnd_shift((n + 4096) * longint'(size - 1) * ONE, 13);
    else u = rnd_shift((n + 4096) * longint'(size) * ONE, 13) - HALF;
    if (cfg.pad_sel == gse_pkg::PAD_BORDER) begin
      if (u < 0) u = 0;
      if (u > top) u = top;
    end else if (cfg.pad_sel == gse_pkg::PAD_REFLECT) begin
      if (cfg.corner_align) begin
        dr = 2 * top;
        if (dr == 0) return 0;
        a = (u < 0) ? -u : u;
        e = a % dr;
        u = (e < dr - e) ? e : dr - e;
      end else begin
        dr = 2 * longint'(size) * ONE;
        a = u + HALF;
        if (a < 0) a = -a;
        e = a % dr;
        u = ((e < dr - e) ? e : dr - e) - HALF;
        if (u < 0) u = 0;
        if (u > top) u = top;
      end
    end
    return u;
  endfunction

  function automatic longint pix_at(longint x, longint y, int w, int h, int c);
    if (x < 0 || y < 0 || x >= w || y >= h) return 0;
    return longint'($signed(pixels[(int'(y) * 64 + int'(x)) * 4 + c]));
  endfunction

  task automatic predict_sample(logic signed [15:0] nx, logic signed [15:0] ny);
    int w, h, nch;
    longint ux, uy, xw, yn, dw, de, dn, ds, sum, v;
    sample_res_t r;
    w = dim_of(cfg.img_width);
    h = dim_of(cfg.img_height);
    nch = (cfg.channel_count < 1) ? 1 : (cfg.channel_count > 4 ? 4 : int'(cfg.channel_count));
    ux = unnorm(longint'(nx), w);
    uy = unnorm(longint'(ny), h);
    for (int c = 0; c < nch; c++) begin
      if (cfg.interp_mode == gse_pkg::INTERP_NEAREST) begin
        v = pix_at(rnd_shift(ux, FB), rnd_shift(uy, FB), w, h, c);
      end else begin
        xw = fl_shift(ux, FB);
        yn = fl_shift(uy, FB);
        dw = ux - xw * ONE; de = ONE - dw;
        dn = uy - yn * ONE; ds = ONE - dn;
        sum = pix_at(xw, yn, w, h, c) * de * ds + pix_at(xw + 1, yn, w, h, c) * dw * ds
            + pix_at(xw, yn + 1, w, h, c) * de * dn
            + pix_at(xw + 1, yn + 1, w, h, c) * dw * dn;
        v = rnd_shift(sum, 2 * FB);
      end
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      r.value = v[15:0];
      r.chan = c[1:0];
      r.last = (c + 1 == nch);
      expected_q.push_back(r);
    end
  endtask

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    fail_count++;
  endtask

  initial fail_count = 0;

  always @(posedge clk) begin
    sample_res_t e;
    if (rst) begin
      cfg <= '{img_width: 7'd64, img_height: 7'd64, channel_count: 3'd1,
               corner_align: 1'b0, pad_sel: 2'd0, interp_mode: 1'b0};
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          gse_pkg::REG_WIDTH:    cfg.img_width <= cfg_data;
          gse_pkg::REG_HEIGHT:   cfg.img_height <= cfg_data;
          gse_pkg::REG_CHANNELS: cfg.channel_count <= cfg_data[2:0];
          gse_pkg::REG_ALIGN:    cfg.corner_align <= cfg_data[0];
          gse_pkg::REG_PADDING:  cfg.pad_sel <= cfg_data[1:0];
          gse_pkg::REG_INTERP:   cfg.interp_mode <= cfg_data[0];
          default: ;
        endcase
      end
      if (start && !busy) begin
        if (mode == gse_pkg::MODE_LOAD) pixels[(int'(pixel_row) * 64 + int'(pixel_col)) * 4
                                               + int'(pixel_chan)] = pixel_value;
        else predict_sample(norm_x, norm_y);
      end
      if (result_strobe) begin
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result", sample_value, 0);
        end else begin
          e = expected_q.pop_front();
          if (sample_value !== e.value) report_mismatch("sample_value", sample_value, e.value);
          if (out_chan !== e.chan) report_mismatch("out_chan", out_chan, e.chan);
          if (last_chan !== e.last) report_mismatch("last_chan", last_chan, e.last);
        end
      end
    end
    pending_count = expected_q.size();
  end

endmodule

// ----- test/tb_grid_sample_engine_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_sample_engine_unit
// Loads small images in every pixel then samples them across padding,
// alignment and interpolation settings, directed edges first then random.
// ----------------------------------------------------------------------------
module tb_grid_sample_engine_unit;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0, mode = 1'b0;
  logic [5:0] pixel_col = '0, pixel_row = '0;
  logic [1:0] pixel_chan = '0;
  logic signed [15:0] pixel_value = '0, norm_x = '0, norm_y = '0;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;
  logic busy, result_strobe, last_chan;
  logic signed [15:0] sample_value;
  logic [1:0] out_chan;
  int fail_count, pending_count;
  int cur_w, cur_h, cur_ch;
  bit calm;

  always #4 clk = ~clk;

  grid_sample_engine_unit u_top (.*);

  grid_sample_checker u_chk (.*);

  task automatic send_item(logic m, logic [5:0] col, logic [5:0] row, logic [1:0] ch,
                           logic [15:0] pv, logic [15:0] nx, logic [15:0] ny);
    if (!calm && $urandom_range(0, 3) == 0) begin
      // Drop start and wander the fields while idle
      start <= 1'b0;
      mode <= 1'($urandom); pixel_col <= 6'($urandom); pixel_row <= 6'($urandom);
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    start <= 1'b1; mode <= m; pixel_col <= col; pixel_row <= row;
    pixel_chan <= ch; pixel_value <= pv; norm_x <= nx; norm_y <= ny;
    do @(posedge clk); while (busy);
  endtask

  // Hold off until every expected result has come
  task automatic wait_results();
    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  task automatic drain_engine();
    wait_results();
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(gse_pkg::cfg_index_t idx, int val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val[6:0];
    @(posedge clk);
  endtask

  // Drain, reconfigure, then load every pixel of every channel in use
  task automatic set_image(int w, int h, int nch, int al, int pad, int ip);
    drain_engine();
    write_reg(gse_pkg::REG_WIDTH, w); write_reg(gse_pkg::REG_HEIGHT, h);
    write_reg(gse_pkg::REG_CHANNELS, nch); write_reg(gse_pkg::REG_ALIGN, al);
    write_reg(gse_pkg::REG_PADDING, pad); write_reg(gse_pkg::REG_INTERP, ip);
    cfg_we <= 1'b0;
    cur_w = (w < 1) ? 1 : w; cur_h = (h < 1) ? 1 : h; cur_ch = (nch < 1) ? 1 : nch;
    for (int r = 0; r < cur_h; r++)
      for (int c = 0; c < cur_w; c++)
        for (int k = 0; k < cur_ch; k++)
          send_item(gse_pkg::MODE_LOAD, 6'(c), 6'(r), 2'(k), ($urandom_range(0, 7) == 0) ?
                    (($urandom & 1) ? 16'h7FFF : 16'h8000) : 16'($urandom),
                    16'($urandom), 16'($urandom));
  endtask

  task automatic sample_at(logic [15:0] nx, logic [15:0] ny);
    send_item(gse_pkg::MODE_SAMPLE, 6'($urandom), 6'($urandom), 2'($urandom),
              16'($urandom), nx, ny);
  endtask

  function automatic logic [15:0] rand_norm();
    case ($urandom_range(0, 5))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 8192)) - 16'd4096;
      2: return 16'($urandom_range(0, 16)) - 16'd4104;
      3: return 16'($urandom_range(0, 16)) + 16'd4088;
      default: return 16'($urandom_range(0, 24576)) - 16'd12288;
    endcase
  endfunction

  initial begin
    calm = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    // directed: edge points, single pixel reflection, extremes of dimensions
    set_image(4, 3, 4, 0, gse_pkg::PAD_ZEROS, 0);
    sample_at(16'h8000, 16'h7FFF); sample_at(16'h7FFF, 16'h8000);
    sample_at(16'hF000, 16'h1000); sample_at(16'h0000, 16'h0000);
    sample_at(16'h0800, 16'hF800);
    set_image(1, 1, 1, 1, gse_pkg::PAD_REFLECT, 0);
    sample_at(16'h7FFF, 16'h8000); sample_at(16'h1234, 16'hC000);
    set_image(1, 2, 2, 0, gse_pkg::PAD_REFLECT, 1);
    sample_at(16'h3000, 16'hD000); sample_at(16'h0000, 16'h1000);
    set_image(2, 2, 3, 1, gse_pkg::PAD_BORDER, 1);
    sample_at(16'h8000, 16'h8000); sample_at(16'h7FFF, 16'h7FFF);
    sample_at(16'h0000, 16'h0000);
    set_image(5, 4, 2, 1, 3, 0);
    sample_at(16'h1000, 16'hF000); sample_at(16'h2000, 16'h0400);
    // random phases over random settings, phase 4 over a 64x1 reflected image
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 4) set_image(64, 1, 1, $urandom_range(0, 1), gse_pkg::PAD_REFLECT, 0);
      else set_image($urandom_range(1, 4), $urandom_range(1, 4), $urandom_range(1, 3),
                     $urandom_range(0, 1), $urandom_range(0, 3), $urandom_range(0, 1));
      if (ph >= 4) calm = 1'b1;
      repeat (12) sample_at(rand_norm(), rand_norm());
      if (ph == 2) wait_results();
    end
    drain_engine();
    if (fail_count == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
src/gse_pkg.sv
src/gse_queue.sv
src/gse_front.sv
src/gse_back.sv
src/grid_sample_engine_unit.sv
src/gse_checker.sv
test/grid_sample_checker.sv
test/tb_grid_sample_engine_unit.sv
